FILE: rtl/uubr_pkg.sv
package uubr_pkg;

	// ring geometry
	localparam int unsigned DEPTH = 256;
	localparam int unsigned PTR_W = $clog2(DEPTH);

	// field widths
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned WORD_W     = 9;
	localparam int unsigned FUNC_W     = 3;
	localparam int unsigned MODE_W     = 3;
	localparam int unsigned HOLD_W     = 16;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 16;

	// transaction function codes
	typedef enum logic [FUNC_W-1:0] {
		FUNC_HOST_IN    = 3'd0,
		FUNC_TX_READY   = 3'd1,
		FUNC_RX_WORD    = 3'd2,
		FUNC_HOST_READY = 3'd3,
		FUNC_TICK       = 3'd4
	} func_t;

	// parity modes that alter data
	localparam logic [MODE_W-1:0] PARITY_MARK  = 3'd3;
	localparam logic [MODE_W-1:0] PARITY_SPACE = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PARITY_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LED_HOLD    = 1'b1;

	localparam logic [HOLD_W-1:0] LED_HOLD_RESET = 16'd100;

	typedef logic [PTR_W-1:0] ptr_t;

	// ring request and status between top and ring
	typedef struct packed {
		logic push;
		logic pop;
	} ring_req_t;

	typedef struct packed {
		logic empty;
		logic pending_next;
	} ring_sts_t;

	// result fields held in the output stage
	typedef struct packed {
		logic word_valid;
		logic from_tx_ring;
		logic mark;
		logic space;
		logic transmit_idle;
		logic word_dropped;
		logic host_data_pending;
		logic receive_led_on;
		logic transmit_led_on;
	} res_t;

	// ring pointer advance with wrap
	function automatic ptr_t next_pos(input ptr_t p);
		ptr_t n;
		n = (p == ptr_t'(DEPTH - 1)) ? '0 : p + ptr_t'(1);
		return n;
	endfunction

endpackage

FILE: rtl/uubr_ifs.sv
interface uubr_item_if;
	logic                           valid;
	logic                           ready;
	logic [uubr_pkg::FUNC_W-1:0]    func;
	logic [uubr_pkg::WORD_W-1:0]    word_in;

	modport source(output valid, func, word_in, input ready);
	modport sink(input valid, func, word_in, output ready);
endinterface

interface uubr_result_if;
	logic                           valid;
	logic                           ready;
	logic                           word_valid;
	logic [uubr_pkg::WORD_W-1:0]    word_out;
	logic                           transmit_idle;
	logic                           word_dropped;
	logic                           host_data_pending;
	logic                           receive_led_on;
	logic                           transmit_led_on;

	modport source(output valid, word_valid, word_out, transmit_idle, word_dropped,
		host_data_pending, receive_led_on, transmit_led_on, input ready);
	modport sink(input valid, word_valid, word_out, transmit_idle, word_dropped,
		host_data_pending, receive_led_on, transmit_led_on, output ready);
endinterface

FILE: rtl/usb_uart_bridge_rings_core.sv
// a transaction passes the input stage, then the result stage that offers its result
// throughput: one transaction per cycle, sustained without output stall
// the ring memories' registered read port sets the second stage
// reset: pointers, indicator counters and config (parity none, hold 100) clear at once
// ring contents are not cleared; there is no clearing pass after reset
module usb_uart_bridge_rings_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [uubr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [uubr_pkg::CFG_DATA_W-1:0]    cfg_data,
	uubr_item_if.sink                          item,
	uubr_result_if.source                      result
);

	logic [uubr_pkg::MODE_W-1:0] parity_mode_q;
	logic [uubr_pkg::HOLD_W-1:0] led_hold_q;
	logic [uubr_pkg::HOLD_W-1:0] rx_led_q, tx_led_q, rx_led_d, tx_led_d;

	logic                        valid_s1, valid_s2;
	uubr_pkg::func_t             func_s1;
	logic [uubr_pkg::WORD_W-1:0] word_s1;
	uubr_pkg::res_t              res_s2, res_d;

	logic advance, step;
	uubr_pkg::ring_req_t         tx_req, rx_req;
	uubr_pkg::ring_sts_t         tx_sts, rx_sts;
	logic [uubr_pkg::BYTE_W-1:0] tx_wdata, rx_wdata, tx_rdata, rx_rdata;
	logic                        mark, space, rx_ok;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_mode_q <= '0;
			led_hold_q    <= uubr_pkg::LED_HOLD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				uubr_pkg::CFG_PARITY_MODE: parity_mode_q <= cfg_data[uubr_pkg::MODE_W-1:0];
				uubr_pkg::CFG_LED_HOLD:    led_hold_q    <= cfg_data[uubr_pkg::HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// flow control
	assign advance    = !valid_s2 || result.ready;
	assign item.ready = !valid_s1 || advance;
	assign step       = valid_s1 && advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			func_s1 <= uubr_pkg::func_t'(item.func);
			word_s1 <= item.word_in;
		end
	end

	assign mark  = (parity_mode_q == uubr_pkg::PARITY_MARK);
	assign space = (parity_mode_q == uubr_pkg::PARITY_SPACE);

	// received word parity check and strip
	always_comb begin
		rx_ok    = 1'b1;
		rx_wdata = word_s1[uubr_pkg::BYTE_W-1:0];
		if (mark) begin
			rx_ok    = word_s1[0];
			rx_wdata = word_s1[uubr_pkg::WORD_W-1:1];
		end else if (space) begin
			rx_ok    = !word_s1[0];
			rx_wdata = word_s1[uubr_pkg::WORD_W-1:1];
		end
	end

	assign tx_wdata = word_s1[uubr_pkg::BYTE_W-1:0];

	// ring requests, indicator counters and result fields
	always_comb begin
		tx_req   = '0;
		rx_req   = '0;
		rx_led_d = rx_led_q;
		tx_led_d = tx_led_q;
		res_d    = '0;
		case (func_s1)
			uubr_pkg::FUNC_HOST_IN: begin
				tx_req.push = step;
			end
			uubr_pkg::FUNC_TX_READY: begin
				tx_req.pop = step;
				if (!tx_sts.empty) begin
					res_d.word_valid   = 1'b1;
					res_d.from_tx_ring = 1'b1;
					res_d.mark         = mark;
					res_d.space        = space;
					tx_led_d           = led_hold_q;
				end else begin
					res_d.transmit_idle = 1'b1;
				end
			end
			uubr_pkg::FUNC_RX_WORD: begin
				if (rx_ok) begin
					rx_req.push = step;
					rx_led_d    = led_hold_q;
				end else begin
					res_d.word_dropped = 1'b1;
				end
			end
			uubr_pkg::FUNC_HOST_READY: begin
				rx_req.pop = step;
				res_d.word_valid = !rx_sts.empty;
			end
			uubr_pkg::FUNC_TICK: begin
				if (rx_led_q != '0) begin
					rx_led_d = rx_led_q - 1'b1;
				end
				if (tx_led_q != '0) begin
					tx_led_d = tx_led_q - 1'b1;
				end
			end
			default: ;
		endcase
		res_d.host_data_pending = rx_sts.pending_next;
		res_d.receive_led_on    = (rx_led_d != '0);
		res_d.transmit_led_on   = (tx_led_d != '0);
	end

	// indicator counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_led_q <= '0;
			tx_led_q <= '0;
		end else if (step) begin
			rx_led_q <= rx_led_d;
			tx_led_q <= tx_led_d;
		end
	end

	// rings
	uubr_ring u_tx_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tx_req),
		.wdata  (tx_wdata),
		.rdata  (tx_rdata),
		.sts    (tx_sts)
	);

	uubr_ring u_rx_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rx_req),
		.wdata  (rx_wdata),
		.rdata  (rx_rdata),
		.sts    (rx_sts)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res_d;
		end
	end

	// output word formatting from ring read data
	always_comb begin
		result.word_out = '0;
		if (res_s2.word_valid) begin
			if (!res_s2.from_tx_ring) begin
				result.word_out = {1'b0, rx_rdata};
			end else if (res_s2.mark) begin
				result.word_out = {tx_rdata, 1'b1};
			end else if (res_s2.space) begin
				result.word_out = {tx_rdata, 1'b0};
			end else begin
				result.word_out = {1'b0, tx_rdata};
			end
		end
	end

	assign result.valid             = valid_s2;
	assign result.word_valid        = res_s2.word_valid;
	assign result.transmit_idle     = res_s2.transmit_idle;
	assign result.word_dropped      = res_s2.word_dropped;
	assign result.host_data_pending = res_s2.host_data_pending;
	assign result.receive_led_on    = res_s2.receive_led_on;
	assign result.transmit_led_on   = res_s2.transmit_led_on;

	// a popped word and an idle report never share a result
	a_valid_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.word_valid && res_s2.transmit_idle))
		else $error("word_valid and transmit_idle both set");

	// a dropped word only happens in mark or space mode
	a_drop_mode: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_d.word_dropped |-> (mark || space))
		else $error("word dropped outside mark or space mode");

	// a stalled result keeps its ring read data
	a_rdata_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !result.ready |=> $stable(tx_rdata) && $stable(rx_rdata))
		else $error("ring read data changed under a stalled result");

	// a push and a pop never hit the same ring in one cycle
	a_ring_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(tx_req.push && tx_req.pop) && !(rx_req.push && rx_req.pop))
		else $error("push and pop on one ring in the same cycle");

endmodule

FILE: rtl/uubr_ram.sv
module uubr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/uubr_ring.sv
module uubr_ring (
	input  logic                          clk,
	input  logic                          arst_n,
	input  uubr_pkg::ring_req_t           req,
	input  logic [uubr_pkg::BYTE_W-1:0]   wdata,
	output logic [uubr_pkg::BYTE_W-1:0]   rdata,
	output uubr_pkg::ring_sts_t           sts
);

	uubr_pkg::ptr_t wr_q, rd_q, wr_d, rd_d, wr_nx;
	logic           empty;
	logic           pop_eff;

	assign empty   = (wr_q == rd_q);
	assign wr_nx   = uubr_pkg::next_pos(wr_q);
	assign pop_eff = req.pop && !empty;

	// pointer update; a push into a full ring drops the oldest byte
	always_comb begin
		wr_d = wr_q;
		rd_d = rd_q;
		if (req.push) begin
			wr_d = wr_nx;
			if (wr_nx == rd_q) begin
				rd_d = uubr_pkg::next_pos(rd_q);
			end
		end else if (pop_eff) begin
			rd_d = uubr_pkg::next_pos(rd_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			wr_q <= wr_d;
			rd_q <= rd_d;
		end
	end

	assign sts.empty        = empty;
	assign sts.pending_next = (wr_d != rd_d);

	// byte storage
	uubr_ram #(
		.WIDTH(uubr_pkg::BYTE_W),
		.DEPTH(uubr_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (req.push),
		.waddr (wr_q),
		.wdata (wdata),
		.re    (pop_eff),
		.raddr (rd_q),
		.rdata (rdata)
	);

endmodule
